@@ rtl/core/ibr1_pkg.sv @@
// Shared types and constants for the ByteRun1 body decoder core.
// No dependencies; imported by ibr1_ctrl, ibr1_dpath and the top level.
package ibr1_pkg;

    localparam int MAX_ROW_BYTES_DEF = 1024;
    localparam int MAX_PLANES_DEF    = 8;
    localparam int MAX_ROWS_DEF      = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int MODE_W     = 8;
    localparam int WIDTH_W    = 14;
    localparam int PLANES_W   = 4;
    localparam int ROWS_W     = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd3;

    localparam logic [MODE_W-1:0]   MODE_RST   = 8'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 14'd320;
    localparam logic [PLANES_W-1:0] PLANES_RST = 4'd5;
    localparam logic [ROWS_W-1:0]   ROWS_RST   = 13'd256;

    localparam logic [MODE_W-1:0] CMP_NONE     = 8'd0;
    localparam logic [MODE_W-1:0] CMP_BYTERUN1 = 8'd1;
    localparam logic [7:0]        CTRL_NOP     = 8'h80;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SHORT   = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;
    localparam logic [1:0] ERR_MODE    = 2'd3;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_REP
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PLACE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic eval;
        logic place;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic has_places;
        logic place_ok;
        logic place_last;
        logic fin_ok;
    } sts_t;

    typedef struct packed {
        logic [7:0]  data_a;
        logic [7:0]  data_b;
        logic [1:0]  byte_count;
        logic [2:0]  plane;
        logic [11:0] row;
        logic [9:0]  column;
        logic        image_done;
        logic [1:0]  error;
    } res_t;

endpackage

@@ rtl/core/ilbm_byterun1_body_decoder_core.sv @@
// Top level of the ByteRun1 (PackBits) body decoder for interleaved bitplanes.
// Depends on ibr1_pkg, ibr1_ctrl and ibr1_dpath.
//
// Takes one raw body byte per transaction and returns decoded bytes in pairs
// tagged with plane, row and column. Each byte is accepted, evaluated, then has
// its decoded bytes placed and is finished: a literal or uncompressed byte places
// one, a repeat byte places n (n up to 128), a control byte places none. The
// single byte-placement step of the datapath handles one decoded byte per cycle
// while the result channel does not hold it back; backpressure there stalls it.
// Configuration must be written while no byte is in flight.
module ilbm_byterun1_body_decoder_core
    import ibr1_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int MAX_PLANES    = MAX_PLANES_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_body_byte,
    input  logic                  s_body_first,
    input  logic                  s_body_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_data_a,
    output logic [7:0]            m_data_b,
    output logic [1:0]            m_byte_count,
    output logic [2:0]            m_plane_index,
    output logic [11:0]           m_row_index,
    output logic [9:0]            m_column,
    output logic                  m_run_last,
    output logic                  m_image_done,
    output logic [1:0]            m_error_code
);

    cmd_t cmd;
    sts_t sts;
    res_t m_res;

    ibr1_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ibr1_dpath #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_PLANES    (MAX_PLANES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_body_byte  (s_body_byte),
        .s_body_first (s_body_first),
        .s_body_last  (s_body_last),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_res        (m_res),
        .m_run_last   (m_run_last)
    );

    assign m_data_a      = m_res.data_a;
    assign m_data_b      = m_res.data_b;
    assign m_byte_count  = m_res.byte_count;
    assign m_plane_index = m_res.plane;
    assign m_row_index   = m_res.row;
    assign m_column      = m_res.column;
    assign m_image_done  = m_res.image_done;
    assign m_error_code  = m_res.error;

endmodule

@@ rtl/core/ibr1_ctrl.sv @@
// Sequencing state machine of the ByteRun1 body decoder.
// Depends on ibr1_pkg; drives ibr1_dpath through cmd_t and reads sts_t.
module ibr1_ctrl
    import ibr1_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (sts.skip)            state_next = ST_IDLE;
                else if (sts.has_places) state_next = ST_PLACE;
                else                     state_next = ST_FIN;
            end
            ST_PLACE: begin
                if (sts.place_ok && sts.place_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.fin_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            ST_PLACE: begin
                cmd.place = sts.place_ok;
            end
            ST_FIN: begin
                cmd.fin = sts.fin_ok;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/ibr1_dpath.sv @@
// Datapath of the ByteRun1 body decoder: config registers, decode state,
// position counters, pair assembly and the result register. Uses ibr1_pkg.
module ibr1_dpath
    import ibr1_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int MAX_PLANES    = MAX_PLANES_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [7:0]            s_body_byte,
    input  logic                  s_body_first,
    input  logic                  s_body_last,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_t                  m_res,
    output logic                  m_run_last
);

    localparam int MRB_EVEN = (MAX_ROW_BYTES / 2) * 2;
    localparam int COL_W    = $clog2(MRB_EVEN);
    localparam int LR_W     = $clog2(MRB_EVEN + 1);
    localparam int PL_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int LP_W     = $clog2(MAX_PLANES + 1);
    localparam int RW_W     = $clog2(MAX_ROWS + 1);

    // config
    logic [MODE_W-1:0]   mode_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [PLANES_W-1:0] planes_reg;
    logic [ROWS_W-1:0]   rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RST;
            width_reg  <= WIDTH_RST;
            planes_reg <= PLANES_RST;
            rows_reg   <= ROWS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_wdata[MODE_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_PLANES: planes_reg <= cfg_wdata[PLANES_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg_wdata[ROWS_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // clamped geometry
    logic [14:0]     w_sum;
    logic [12:0]     rb13;
    logic [12:0]     lr13;
    logic [3:0]      lp4;
    logic [15:0]     lh16;
    logic [LR_W-1:0] lim_r;
    logic [LP_W-1:0] lim_p;
    logic [RW_W-1:0] lim_h;

    always_comb begin
        w_sum = {1'b0, width_reg} + 15'd15;
        rb13  = {1'b0, w_sum[14:4], 1'b0};
        if (rb13 > 13'(MRB_EVEN)) lr13 = 13'(MRB_EVEN);
        else if (rb13 < 13'd2)    lr13 = 13'd2;
        else                      lr13 = rb13;
        if (planes_reg > 4'(MAX_PLANES)) lp4 = 4'(MAX_PLANES);
        else if (planes_reg == 4'd0)     lp4 = 4'd1;
        else                             lp4 = planes_reg;
        if ({3'b000, rows_reg} > 16'(MAX_ROWS)) lh16 = 16'(MAX_ROWS);
        else if (rows_reg == 13'd0)              lh16 = 16'd1;
        else                                     lh16 = {3'b000, rows_reg};
        lim_r = LR_W'(lr13);
        lim_p = LP_W'(lp4);
        lim_h = RW_W'(lh16);
    end

    // state
    phase_t          phase_reg;
    logic [7:0]      run_reg;
    logic [COL_W-1:0] col_reg;
    logic [PL_W-1:0] plane_reg;
    logic [RW_W-1:0] row_reg;
    logic            finished_reg;
    logic [1:0]      fault_reg;
    logic            pend_valid_reg;
    logic            out_valid_reg;
    logic [7:0]      held_reg;
    logic [7:0]      byte_reg;
    logic            last_reg;
    logic [1:0]      err_reg;
    logic [7:0]      place_left_reg;
    res_t            pend_reg;
    res_t            out_reg;
    logic            out_last_reg;

    // control byte evaluation
    logic [LR_W-1:0] col_ext;
    logic [LR_W-1:0] avail;
    logic [7:0]      ctl_cnt;
    phase_t          ev_phase;
    logic [7:0]      ev_run;
    logic [1:0]      ev_err;
    logic [7:0]      ev_places;

    always_comb begin
        col_ext   = LR_W'(col_reg);
        avail     = (col_ext >= lim_r) ? '0 : lim_r - col_ext;
        ctl_cnt   = (byte_reg < CTRL_NOP) ? byte_reg + 8'd1 : 8'(9'd257 - {1'b0, byte_reg});
        ev_phase  = phase_reg;
        ev_run    = run_reg;
        ev_err    = ERR_NONE;
        ev_places = 8'd0;
        if (mode_reg > CMP_BYTERUN1) begin
            ev_err = ERR_MODE;
        end else if (mode_reg == CMP_NONE) begin
            ev_places = 8'd1;
        end else if (phase_reg == PH_LIT && run_reg != 8'd0) begin
            ev_places = 8'd1;
            ev_run    = run_reg - 8'd1;
            ev_phase  = (run_reg == 8'd1) ? PH_CTRL : PH_LIT;
        end else if (phase_reg == PH_REP && run_reg != 8'd0) begin
            ev_run   = 8'd0;
            ev_phase = PH_CTRL;
            if (13'(run_reg) > 13'(avail)) ev_err    = ERR_OVERRUN;
            else                            ev_places = run_reg;
        end else begin
            ev_run   = 8'd0;
            ev_phase = PH_CTRL;
            if (byte_reg != CTRL_NOP) begin
                if (13'(ctl_cnt) > 13'(avail)) begin
                    ev_err = ERR_OVERRUN;
                end else begin
                    ev_run   = ctl_cnt;
                    ev_phase = (byte_reg < CTRL_NOP) ? PH_LIT : PH_REP;
                end
            end
        end
    end

    // one byte placement
    logic [LR_W-1:0] col_p1;
    logic [LP_W-1:0] plane_p1;
    logic [RW_W-1:0] row_p1;
    logic            wrap;
    logic            plane_wrap;
    logic            done_now;
    logic            emits;
    res_t            new_res;

    always_comb begin
        col_p1     = col_ext + LR_W'(1);
        plane_p1   = LP_W'(plane_reg) + LP_W'(1);
        row_p1     = row_reg + RW_W'(1);
        wrap       = col_p1 >= lim_r;
        plane_wrap = plane_p1 >= lim_p;
        done_now   = wrap && plane_wrap && (row_p1 >= lim_h);
        emits      = col_reg[0] | wrap;
        new_res.data_a     = col_reg[0] ? held_reg : byte_reg;
        new_res.data_b     = col_reg[0] ? byte_reg : 8'd0;
        new_res.byte_count = col_reg[0] ? 2'd2 : 2'd1;
        new_res.plane      = 3'(plane_reg);
        new_res.row        = 12'(row_reg);
        new_res.column     = col_reg[0] ? 10'(col_reg - COL_W'(1)) : 10'(col_reg);
        new_res.image_done = done_now;
        new_res.error      = ERR_NONE;
    end

    // step finish
    logic [1:0] err_fin;
    logic       send;
    logic       out_free;
    res_t       fin_res;

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        if (err_reg != ERR_NONE)           err_fin = err_reg;
        else if (last_reg && !finished_reg) err_fin = ERR_SHORT;
        else                               err_fin = ERR_NONE;
        send = pend_valid_reg || (err_fin != ERR_NONE);
        if (pend_valid_reg) begin
            fin_res = pend_reg;
        end else begin
            fin_res            = '0;
            fin_res.plane      = 3'(plane_reg);
            fin_res.row        = 12'(row_reg);
            fin_res.column     = 10'(col_reg);
        end
        if (err_fin != ERR_NONE) fin_res.error = err_fin;
    end

    always_comb begin
        sts.skip       = finished_reg || (fault_reg != ERR_NONE);
        sts.has_places = ev_places != 8'd0;
        sts.place_ok   = !(pend_valid_reg && out_valid_reg && !m_ready);
        sts.place_last = (place_left_reg == 8'd1) || done_now;
        sts.fin_ok     = !send || out_free;
    end

    logic load_from_pend;
    logic load_from_fin;

    assign load_from_pend = cmd.place && emits && pend_valid_reg;
    assign load_from_fin  = cmd.fin && send;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_CTRL;
            run_reg        <= 8'd0;
            col_reg        <= '0;
            plane_reg      <= '0;
            row_reg        <= '0;
            finished_reg   <= 1'b0;
            fault_reg      <= ERR_NONE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept && s_body_first) begin
                phase_reg    <= PH_CTRL;
                run_reg      <= 8'd0;
                col_reg      <= '0;
                plane_reg    <= '0;
                row_reg      <= '0;
                finished_reg <= 1'b0;
                fault_reg    <= ERR_NONE;
            end
            if (cmd.eval && !sts.skip) begin
                phase_reg <= ev_phase;
                run_reg   <= ev_run;
            end
            if (cmd.place) begin
                if (wrap) begin
                    col_reg <= '0;
                    if (plane_wrap) begin
                        plane_reg <= '0;
                        row_reg   <= row_p1;
                        if (done_now) finished_reg <= 1'b1;
                    end else begin
                        plane_reg <= PL_W'(plane_p1);
                    end
                end else begin
                    col_reg <= COL_W'(col_p1);
                end
                if (emits) pend_valid_reg <= 1'b1;
            end
            if (cmd.fin) begin
                pend_valid_reg <= 1'b0;
                if (err_fin != ERR_NONE) fault_reg <= err_fin;
            end
            if (load_from_pend || load_from_fin) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_body_byte;
            last_reg <= s_body_last;
        end
        if (cmd.eval) begin
            err_reg        <= ev_err;
            place_left_reg <= ev_places;
        end
        if (cmd.place) begin
            place_left_reg <= place_left_reg - 8'd1;
            if (!col_reg[0]) held_reg <= byte_reg;
            if (emits) pend_reg <= new_res;
        end
        if (load_from_pend) begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b0;
        end else if (load_from_fin) begin
            out_reg      <= fin_res;
            out_last_reg <= 1'b1;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_res      = out_reg;
    assign m_run_last = out_last_reg;

    a_status_has_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.byte_count == 2'd0 |-> out_reg.error != ERR_NONE)
        else $error("status-only transaction without error code");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.image_done |-> out_last_reg)
        else $error("image_done on a transaction that is not the last of its byte");

    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !pend_valid_reg)
        else $error("new byte accepted with a pending result");

    a_place_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.place |-> place_left_reg != 8'd0)
        else $error("placement beyond the decoded run length");

endmodule

@@ bench/ilbm_byterun1_body_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ilbm_byterun1_body_decoder_core: directed and random ByteRun1 bodies.
// Depends on ibr1_pkg and the decoder core; a tracker class predicts and checks every result.
module ilbm_byterun1_body_decoder_core_tb;
    import ibr1_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT      = 4000;
    localparam int SETTLE_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE  = 38;
    localparam int MAX_STEP_RESULTS = 64;
    localparam int BODY_BUF_DEPTH   = 4096;

    typedef struct packed {
        logic [7:0]  data_a;
        logic [7:0]  data_b;
        logic [1:0]  byte_count;
        logic [2:0]  plane_index;
        logic [11:0] row_index;
        logic [9:0]  column;
        logic        run_last;
        logic        image_done;
        logic [1:0]  error_code;
    } decoded_t;

    typedef struct {
        logic [7:0] value;
        logic       first;
        logic       last;
    } body_item_t;

    class body_decode_tracker;
        logic [MODE_W-1:0]   mode_reg;
        logic [WIDTH_W-1:0]  width_reg;
        logic [PLANES_W-1:0] planes_reg;
        logic [ROWS_W-1:0]   rows_reg;
        phase_t     phase;
        int         run_left;
        int         col_pos;
        int         plane_pos;
        int         row_pos;
        bit         finished;
        logic [1:0] fault;
        logic [7:0] held;
        int         row_bytes;
        int         plane_lim;
        int         row_lim;
        decoded_t   step_res[MAX_STEP_RESULTS];
        int         step_n;
        decoded_t   pending[$];
        int         mismatch_count;

        function new();
            mode_reg       = MODE_RST;
            width_reg      = WIDTH_RST;
            planes_reg     = PLANES_RST;
            rows_reg       = ROWS_RST;
            mismatch_count = 0;
            restart();
            update_limits();
        endfunction

        function void restart();
            phase     = PH_CTRL;
            run_left  = 0;
            col_pos   = 0;
            plane_pos = 0;
            row_pos   = 0;
            finished  = 0;
            fault     = ERR_NONE;
            held      = 8'd0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MODE:   mode_reg   = val[MODE_W-1:0];
                CFG_WIDTH:  width_reg  = val[WIDTH_W-1:0];
                CFG_PLANES: planes_reg = val[PLANES_W-1:0];
                CFG_ROWS:   rows_reg   = val[ROWS_W-1:0];
                default: ;
            endcase
        endfunction

        function void update_limits();
            int w;
            int cap;
            w = int'(width_reg);
            row_bytes = ((w + 15) >> 4) << 1;
            cap = MAX_ROW_BYTES_DEF & ~1;
            if (cap < 2) cap = 2;
            if (row_bytes > cap) row_bytes = cap;
            if (row_bytes < 2) row_bytes = 2;
            plane_lim = int'(planes_reg);
            if (plane_lim > MAX_PLANES_DEF) plane_lim = MAX_PLANES_DEF;
            if (plane_lim < 1) plane_lim = 1;
            row_lim = int'(rows_reg);
            if (row_lim > MAX_ROWS_DEF) row_lim = MAX_ROWS_DEF;
            if (row_lim < 1) row_lim = 1;
        endfunction

        function void push_result(logic [7:0] a, logic [7:0] b, logic [1:0] cnt, int col,
                                  logic [1:0] err);
            decoded_t r;
            if (step_n >= MAX_STEP_RESULTS) return;
            r.data_a      = a;
            r.data_b      = b;
            r.byte_count  = cnt;
            r.plane_index = plane_pos[2:0];
            r.row_index   = row_pos[11:0];
            r.column      = col[9:0];
            r.run_last    = 1'b0;
            r.image_done  = 1'b0;
            r.error_code  = err;
            step_res[step_n] = r;
            step_n++;
        endfunction

        function void place_byte(logic [7:0] v);
            if (col_pos[0] == 1'b0)
                held = v;
            else
                push_result(held, v, 2'd2, col_pos - 1, ERR_NONE);
            col_pos++;
            if (col_pos >= row_bytes) begin
                // row may end on an odd column after a width change
                if (col_pos[0]) push_result(held, 8'd0, 2'd1, col_pos - 1, ERR_NONE);
                col_pos = 0;
                plane_pos++;
                if (plane_pos >= plane_lim) begin
                    plane_pos = 0;
                    row_pos++;
                    if (row_pos >= row_lim) begin
                        finished = 1;
                        if (step_n > 0) step_res[step_n-1].image_done = 1'b1;
                    end
                end
            end
        endfunction

        function void take_body_byte(logic [7:0] v, logic first, logic last);
            int avail;
            int cnt;
            logic [1:0] err;
            step_n = 0;
            err = ERR_NONE;
            if (first) restart();
            if (finished || fault != ERR_NONE) return;
            update_limits();
            if (mode_reg > CMP_BYTERUN1) begin
                err = ERR_MODE;
            end else if (mode_reg == CMP_NONE) begin
                place_byte(v);
            end else begin
                avail = (col_pos < row_bytes) ? row_bytes - col_pos : 0;
                if (phase == PH_LIT && run_left != 0) begin
                    place_byte(v);
                    run_left--;
                    if (run_left == 0 || finished) begin
                        run_left = 0;
                        phase = PH_CTRL;
                    end
                end else if (phase == PH_REP && run_left != 0) begin
                    cnt = run_left;
                    run_left = 0;
                    phase = PH_CTRL;
                    if (cnt > avail)
                        err = ERR_OVERRUN;
                    else
                        for (int i = 0; i < cnt && !finished; i++) place_byte(v);
                end else begin
                    phase = PH_CTRL;
                    run_left = 0;
                    if (v != CTRL_NOP) begin
                        cnt = (v < 8'h80) ? int'(v) + 1 : 257 - int'(v);
                        if (cnt > avail) begin
                            err = ERR_OVERRUN;
                        end else begin
                            run_left = cnt;
                            if (v < 8'h80)
                                phase = PH_LIT;
                            else
                                phase = PH_REP;
                        end
                    end
                end
            end
            if (err == ERR_NONE && last && !finished) err = ERR_SHORT;
            if (err != ERR_NONE) begin
                fault = err;
                if (step_n > 0)
                    step_res[step_n-1].error_code = err;
                else
                    push_result(8'd0, 8'd0, 2'd0, col_pos, err);
            end
            if (step_n > 0) step_res[step_n-1].run_last = 1'b1;
            for (int i = 0; i < step_n; i++) pending.push_back(step_res[i]);
        endfunction

        task log_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                log_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task match_decoded(decoded_t got);
            decoded_t want;
            if (pending.size() == 0) begin
                log_mismatch("result transaction with nothing pending");
                return;
            end
            want = pending.pop_front();
            check_field("data_a", int'(got.data_a), int'(want.data_a));
            check_field("data_b", int'(got.data_b), int'(want.data_b));
            check_field("byte_count", int'(got.byte_count), int'(want.byte_count));
            check_field("plane_index", int'(got.plane_index), int'(want.plane_index));
            check_field("row_index", int'(got.row_index), int'(want.row_index));
            check_field("column", int'(got.column), int'(want.column));
            check_field("run_last", int'(got.run_last), int'(want.run_last));
            check_field("image_done", int'(got.image_done), int'(want.image_done));
            check_field("error_code", int'(got.error_code), int'(want.error_code));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_body_byte;
    logic                  s_body_first;
    logic                  s_body_last;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_data_a;
    logic [7:0]            m_data_b;
    logic [1:0]            m_byte_count;
    logic [2:0]            m_plane_index;
    logic [11:0]           m_row_index;
    logic [9:0]            m_column;
    logic                  m_run_last;
    logic                  m_image_done;
    logic [1:0]            m_error_code;

    body_decode_tracker sb;
    body_item_t         body_buf[BODY_BUF_DEPTH];
    int                 body_len;
    int                 items_sent;
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    bit                 rx_long_hold;
    int                 quiet_cycles;
    decoded_t           seen_result;

    ilbm_byterun1_body_decoder_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_body_byte   (s_body_byte),
        .s_body_first  (s_body_first),
        .s_body_last   (s_body_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_a      (m_data_a),
        .m_data_b      (m_data_b),
        .m_byte_count  (m_byte_count),
        .m_plane_index (m_plane_index),
        .m_row_index   (m_row_index),
        .m_column      (m_column),
        .m_run_last    (m_run_last),
        .m_image_done  (m_image_done),
        .m_error_code  (m_error_code)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.take_body_byte(s_body_byte, s_body_first, s_body_last);
            if (m_valid && m_ready) begin
                seen_result.data_a      = m_data_a;
                seen_result.data_b      = m_data_b;
                seen_result.byte_count  = m_byte_count;
                seen_result.plane_index = m_plane_index;
                seen_result.row_index   = m_row_index;
                seen_result.column      = m_column;
                seen_result.run_last    = m_run_last;
                seen_result.image_done  = m_image_done;
                seen_result.error_code  = m_error_code;
                sb.match_decoded(seen_result);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                rx_long_hold = 0;
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_body(input logic [7:0] v, input logic f, input logic l);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_body_byte  <= v;
        s_body_first <= f;
        s_body_last  <= l;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, CFG_DATA_W'(val));
        @(negedge aclk);
    endtask

    task automatic pick_config();
        int sel;
        int w;
        int p;
        int h;
        bit wide;
        wait_drained();
        sel  = $urandom_range(99);
        w    = $urandom_range(1, 64);
        p    = $urandom_range(1, 3);
        h    = $urandom_range(1, 2);
        wide = ($urandom_range(7) == 0);
        if ($urandom_range(19) == 0) w = 0;
        if ($urandom_range(9) == 0) begin
            p = $urandom_range(1) ? 0 : $urandom_range(9, 15);
            h = 1;
        end
        if ($urandom_range(9) == 0) h = 0;
        if (wide) begin
            w = ($urandom_range(3) == 0) ? 8192 : $urandom_range(1000, 2047);
            p = 1;
            h = 1;
        end
        if (wide || sel < 80)
            write_reg(CFG_MODE, CMP_BYTERUN1);
        else if (sel < 95)
            write_reg(CFG_MODE, CMP_NONE);
        else
            write_reg(CFG_MODE, int'($urandom_range(2, 255)));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_PLANES, p);
        write_reg(CFG_ROWS, h);
        sb.update_limits();
    endtask

    function automatic void add_body(logic [7:0] v);
        body_buf[body_len].value = v;
        body_buf[body_len].first = 1'b0;
        body_buf[body_len].last  = 1'b0;
        body_len++;
    endfunction

    // well-formed image body for the current settings, sometimes truncated or corrupted
    task automatic build_image();
        int r;
        int p;
        int h;
        int col;
        int n;
        int kind;
        int aim;
        int rep_pct;
        body_len = 0;
        r       = sb.row_bytes;
        p       = sb.plane_lim;
        h       = sb.row_lim;
        kind    = $urandom_range(9);
        rep_pct = (r > 16) ? 90 : 50;
        if (sb.mode_reg > CMP_BYTERUN1) begin
            repeat ($urandom_range(1, 3)) add_body(8'($urandom_range(255)));
        end else if (sb.mode_reg == CMP_NONE) begin
            repeat (r * p * h) add_body(8'($urandom_range(255)));
        end else begin
            aim = (kind == 8) ? $urandom_range(0, p * h * 4) : -1;
            for (int rr = 0; rr < h; rr++) begin
                for (int pp = 0; pp < p; pp++) begin
                    col = 0;
                    while (col < r) begin
                        if ($urandom_range(11) == 0) add_body(CTRL_NOP);
                        if (aim == 0 && r - col < 128) add_body(8'(r - col));
                        aim--;
                        n = $urandom_range(1, (r - col < 128) ? r - col : 128);
                        if (n > 1 && $urandom_range(99) < rep_pct) begin
                            add_body(8'(257 - n));
                            add_body(8'($urandom_range(255)));
                        end else begin
                            add_body(8'(n - 1));
                            repeat (n) add_body(8'($urandom_range(255)));
                        end
                        col += n;
                    end
                end
            end
        end
        body_buf[0].first = 1'b1;
        if (kind == 7 && body_len > 1) begin
            body_len = $urandom_range(1, body_len - 1);
            body_buf[body_len-1].last = 1'b1;
        end else begin
            if (kind == 9)
                body_buf[$urandom_range(body_len - 1)].value = 8'($urandom_range(255));
            if ($urandom_range(3) != 0) begin
                body_buf[body_len-1].last = 1'b1;
            end else begin
                repeat ($urandom_range(1, 2)) begin
                    add_body(8'($urandom_range(255)));
                    body_buf[body_len-1].last = 1'($urandom_range(1));
                end
            end
        end
    endtask

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_MODE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_body_byte  = 8'd0;
        s_body_first = 1'b0;
        s_body_last  = 1'b0;
        items_sent   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_long_hold = 0;
        quiet_cycles = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: no-op, literal, repeat, then an oversized run
        send_body(CTRL_NOP, 1'b1, 1'b0);
        send_body(8'h00, 1'b0, 1'b0);
        send_body(8'hFF, 1'b0, 1'b0);
        send_body(8'hFE, 1'b0, 1'b0);
        send_body(8'h00, 1'b0, 1'b0);
        send_body(8'h81, 1'b0, 1'b0);
        send_body(8'h12, 1'b0, 1'b1);

        wait_drained();
        write_reg(CFG_MODE, 255);
        send_body(8'h00, 1'b1, 1'b0);

        // uncompressed, width shrinks mid-row so the row ends on an odd column
        wait_drained();
        write_reg(CFG_MODE, CMP_NONE);
        write_reg(CFG_WIDTH, 64);
        write_reg(CFG_PLANES, 1);
        write_reg(CFG_ROWS, 1);
        send_body(8'hAA, 1'b1, 1'b0);
        send_body(8'h55, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_WIDTH, 16);
        send_body(8'h3C, 1'b0, 1'b0);
        send_body(8'h99, 1'b0, 1'b0);

        // repeat count no longer fits when its data byte arrives
        wait_drained();
        write_reg(CFG_MODE, CMP_BYTERUN1);
        write_reg(CFG_WIDTH, 64);
        write_reg(CFG_PLANES, 8);
        write_reg(CFG_ROWS, 8191);
        send_body(8'hFD, 1'b1, 1'b0);
        wait_drained();
        write_reg(CFG_WIDTH, 16);
        send_body(8'h77, 1'b0, 1'b0);

        // widest row, longest repeats, body ends early
        wait_drained();
        write_reg(CFG_WIDTH, 16383);
        write_reg(CFG_PLANES, 0);
        write_reg(CFG_ROWS, 0);
        send_body(8'h81, 1'b1, 1'b0);
        send_body(8'h00, 1'b0, 1'b0);
        send_body(8'h81, 1'b0, 1'b0);
        send_body(8'hFF, 1'b0, 1'b0);
        send_body(CTRL_NOP, 1'b0, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            int target;
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            pick_config();
            if (ph == 0) rx_long_hold = 1;
            while (items_sent < target) begin
                build_image();
                for (int i = 0; i < body_len && items_sent < target; i++)
                    send_body(body_buf[i].value, body_buf[i].first, body_buf[i].last);
                if ($urandom_range(1)) pick_config();
            end
        end

        wait_drained();
        repeat (50) @(negedge aclk);
        if (sb.pending.size() != 0)
            sb.log_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
        if (sb.mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
